// ===== hdl/fcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the fair chunk dispatcher
// Default sizes, operation codes and result status codes.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int JOB_SLOTS_DEF     = 16;
    localparam int INDEX_BITS_DEF    = 24;
    localparam int INFLIGHT_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_CLAIM  = 2'd1,
        OP_FINISH = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_GRANTED  = 3'd1,
        ST_NO_WORK  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_COMPLETE = 3'd4,
        ST_REJECTED = 3'd5,
        ST_IGNORED  = 3'd6
    } t_status;

endpackage

// ===== hdl/fair_chunk_dispatcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_chunk_dispatcher_unit: round-robin chunk dispatcher for parallel jobs
// Keeps a table of jobs and a circular ready order, and hands out index
// chunks to workers in turn.
// ----------------------------------------------------------------------------
// Usage:
// A command is transferred at a rising edge where start is high and busy is
// low; i_op selects submit, claim or finish, and i_job_slot, i_total and
// i_grain carry its operands. Every command yields exactly one result, shown
// on the o_ ports for one cycle while o_valid is high. The receiver cannot
// stall the block, so a result is simply taken in that cycle.
// Rejected submits, unused opcodes, finishes on a free slot and claims on an
// empty ready order end in the dispatch state; an accepted submit adds the
// grant state, any other finish the finish wait state. A granted claim runs
// queue wait, table wait, clip, advance (if the grain is smaller than the
// range left) and grant, plus table and queue wait per exhausted job and
// queue wait per free or completed head job dropped. busy is low again in
// the result cycle, so the next command may be transferred there.
// The rate is set by the single job table port and the one shared
// add/subtract unit, which a claim visits in several sequencer steps.
// Reset clears the busy and done flags, the ready order pointers and the
// live job count; the job table itself is not cleared, since an entry is
// read only after a submit has written it.
// ----------------------------------------------------------------------------
module fair_chunk_dispatcher_unit #(
    parameter int JOB_SLOTS     = fcd_pkg::JOB_SLOTS_DEF,
    parameter int INDEX_BITS    = fcd_pkg::INDEX_BITS_DEF,
    parameter int INFLIGHT_BITS = fcd_pkg::INFLIGHT_BITS_DEF,
    parameter int SLOT_BITS     = $clog2(JOB_SLOTS),
    parameter int CNT_BITS      = $clog2(JOB_SLOTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_op,
    input  logic [SLOT_BITS-1:0]  i_job_slot,
    input  logic [INDEX_BITS-1:0] i_total,
    input  logic [INDEX_BITS-1:0] i_grain,
    output logic                  o_valid,
    output fcd_pkg::t_status      o_status,
    output logic [SLOT_BITS-1:0]  o_slot_out,
    output logic [INDEX_BITS-1:0] o_range_lo,
    output logic [INDEX_BITS-1:0] o_range_hi,
    output logic [CNT_BITS-1:0]   o_jobs_active
);
    import fcd_pkg::*;

    localparam logic [INFLIGHT_BITS-1:0] INF_MAX = '1;

    typedef struct packed {
        logic [INDEX_BITS-1:0]    total;
        logic [INDEX_BITS-1:0]    grain;
        logic [INDEX_BITS-1:0]    next;
        logic [INFLIGHT_BITS-1:0] inflight;
    } t_entry;

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_QWAIT    = 8'b0000_0100,
        S_CWAIT    = 8'b0000_1000,
        S_CLIP     = 8'b0001_0000,
        S_ADV      = 8'b0010_0000,
        S_GRANT    = 8'b0100_0000,
        S_FWAIT    = 8'b1000_0000
    } t_state;

    // Job table and ready order memories, read data registered.
    t_entry               tbl_mem [JOB_SLOTS];
    logic [SLOT_BITS-1:0] q_mem   [JOB_SLOTS];
    t_entry               r_tbl_q;
    logic [SLOT_BITS-1:0] r_q_q;

    logic                 tbl_we;
    logic [SLOT_BITS-1:0] tbl_wa;
    t_entry               tbl_wd;
    logic [SLOT_BITS-1:0] tbl_ra;
    logic                 q_we;
    logic [SLOT_BITS-1:0] q_wa;

    // Control state.
    t_state                r_state, n_state;
    logic [JOB_SLOTS-1:0]  r_busy_flags, n_busy_flags;
    logic [JOB_SLOTS-1:0]  r_done_flags, n_done_flags;
    logic [SLOT_BITS-1:0]  r_first, n_first;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_live, n_live;
    logic                  r_valid, n_valid;

    // Command and work registers.
    t_op                   r_op, n_op;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [INDEX_BITS-1:0] r_total, n_total;
    logic [INDEX_BITS-1:0] r_grain, n_grain;
    t_entry                r_ent, n_ent;
    logic [INDEX_BITS-1:0] r_rem, n_rem;
    logic [INDEX_BITS-1:0] r_end, n_end;
    logic                  r_more, n_more;

    // Result registers.
    t_status               r_status, n_status;
    logic [SLOT_BITS-1:0]  r_slot_out, n_slot_out;
    logic [INDEX_BITS-1:0] r_begin_out, n_begin_out;
    logic [INDEX_BITS-1:0] r_end_out, n_end_out;

    // Shared add/subtract unit. With au_sub set, the carry out means a >= b.
    logic [INDEX_BITS-1:0] au_a, au_b;
    logic                  au_sub;
    logic [INDEX_BITS:0]   au_sum;
    logic                  au_ge;
    logic                  au_zero;

    assign au_sum  = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)}
                   + {{INDEX_BITS{1'b0}}, au_sub};
    assign au_ge   = au_sum[INDEX_BITS];
    assign au_zero = (au_sum[INDEX_BITS-1:0] == '0);

    // Lowest free slot.
    logic [SLOT_BITS-1:0] free_idx;
    logic                 free_found;

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy_flags[i]) begin
                free_idx   = SLOT_BITS'(i);
                free_found = 1'b1;
            end
        end
    end

    // Tail position of the ready order and the head after a pop.
    logic [CNT_BITS:0]    tail_sum;
    logic [SLOT_BITS-1:0] tail_idx;
    logic [SLOT_BITS-1:0] first_inc;

    assign tail_sum = (CNT_BITS + 1)'(r_first) + (CNT_BITS + 1)'(r_count);
    assign tail_idx = (32'(tail_sum) >= JOB_SLOTS)
                    ? SLOT_BITS'(32'(tail_sum) - JOB_SLOTS)
                    : SLOT_BITS'(tail_sum);
    assign first_inc = (32'(r_first) == JOB_SLOTS - 1) ? '0 : r_first + 1'b1;

    logic [SLOT_BITS-1:0] head_job;
    assign head_job = r_q_q;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        r_tbl_q <= tbl_mem[tbl_ra];
        if (q_we) begin
            q_mem[q_wa] <= r_slot;
        end
        r_q_q <= q_mem[r_first];
    end

    always_comb begin
        n_state      = r_state;
        n_busy_flags = r_busy_flags;
        n_done_flags = r_done_flags;
        n_first      = r_first;
        n_count      = r_count;
        n_live       = r_live;
        n_valid      = 1'b0;
        n_op         = r_op;
        n_slot       = r_slot;
        n_total      = r_total;
        n_grain      = r_grain;
        n_ent        = r_ent;
        n_rem        = r_rem;
        n_end        = r_end;
        n_more       = r_more;
        n_status     = r_status;
        n_slot_out   = r_slot_out;
        n_begin_out  = r_begin_out;
        n_end_out    = r_end_out;

        tbl_we = 1'b0;
        tbl_wa = r_slot;
        tbl_wd = r_ent;
        tbl_ra = r_slot;
        q_we   = 1'b0;
        q_wa   = tail_idx;

        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_op);
                    n_slot  = i_job_slot;
                    n_total = i_total;
                    n_grain = (i_grain == '0) ? INDEX_BITS'(1) : i_grain;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_begin_out = '0;
                n_end_out   = '0;
                case (r_op)
                    OP_SUBMIT: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (r_total == '0 || !free_found) begin
                            n_status   = ST_REJECTED;
                            n_slot_out = '0;
                        end else begin
                            tbl_we      = 1'b1;
                            tbl_wa      = free_idx;
                            tbl_wd      = '{total: r_total, grain: r_grain,
                                            next: '0, inflight: '0};
                            n_busy_flags[free_idx] = 1'b1;
                            n_done_flags[free_idx] = 1'b0;
                            // Queue write data comes from r_slot.
                            n_slot = free_idx;
                            n_live = r_live + 1'b1;
                            n_status   = ST_ACCEPTED;
                            n_slot_out = free_idx;
                            // The push is done in S_GRANT style below.
                            if (32'(r_count) < JOB_SLOTS) begin
                                n_state = S_GRANT;
                                n_valid = 1'b0;
                                n_more  = 1'b1;
                            end
                        end
                    end
                    OP_CLAIM: begin
                        if (r_count == '0) begin
                            n_valid    = 1'b1;
                            n_status   = ST_NO_WORK;
                            n_slot_out = '0;
                            n_state    = S_IDLE;
                        end else begin
                            n_first = first_inc;
                            n_count = r_count - 1'b1;
                            n_state = S_QWAIT;
                        end
                    end
                    OP_FINISH: begin
                        if (32'(r_slot) >= JOB_SLOTS || !r_busy_flags[r_slot]) begin
                            n_valid    = 1'b1;
                            n_status   = ST_IGNORED;
                            n_slot_out = r_slot;
                            n_state    = S_IDLE;
                        end else begin
                            tbl_ra  = r_slot;
                            n_state = S_FWAIT;
                        end
                    end
                    default: begin
                        n_valid    = 1'b1;
                        n_status   = ST_IGNORED;
                        n_slot_out = '0;
                        n_state    = S_IDLE;
                    end
                endcase
            end

            S_QWAIT: begin
                // The popped head entry has arrived.
                n_slot = head_job;
                if (!r_busy_flags[head_job] || r_done_flags[head_job]) begin
                    if (r_count == '0) begin
                        n_valid    = 1'b1;
                        n_status   = ST_NO_WORK;
                        n_slot_out = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_first = first_inc;
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    tbl_ra  = head_job;
                    n_state = S_CWAIT;
                end
            end

            S_CWAIT: begin
                n_ent  = r_tbl_q;
                au_a   = r_tbl_q.total;
                au_b   = r_tbl_q.next;
                au_sub = 1'b1;
                n_rem  = au_sum[INDEX_BITS-1:0];
                if (!au_ge || au_zero) begin
                    // Job exhausted: drop it and look at the next head.
                    if (r_count == '0) begin
                        n_valid    = 1'b1;
                        n_status   = ST_NO_WORK;
                        n_slot_out = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_first = first_inc;
                        n_count = r_count - 1'b1;
                        n_state = S_QWAIT;
                    end
                end else begin
                    n_state = S_CLIP;
                end
            end

            S_CLIP: begin
                au_a   = r_rem;
                au_b   = r_ent.grain;
                au_sub = 1'b1;
                if (!au_ge || au_zero) begin
                    // The grain covers the rest of the range.
                    n_end   = r_ent.total;
                    n_more  = 1'b0;
                    n_state = S_GRANT;
                end else begin
                    n_more  = 1'b1;
                    n_state = S_ADV;
                end
            end

            S_ADV: begin
                au_a    = r_ent.next;
                au_b    = r_ent.grain;
                n_end   = au_sum[INDEX_BITS-1:0];
                n_state = S_GRANT;
            end

            S_GRANT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (r_op == OP_CLAIM) begin
                    tbl_we        = 1'b1;
                    tbl_wa        = r_slot;
                    tbl_wd        = r_ent;
                    tbl_wd.next   = r_end;
                    if (r_ent.inflight != INF_MAX) begin
                        tbl_wd.inflight = r_ent.inflight + 1'b1;
                    end
                    n_status    = ST_GRANTED;
                    n_slot_out  = r_slot;
                    n_begin_out = r_ent.next;
                    n_end_out   = r_end;
                end
                // Push the slot at the tail when the job has range left.
                if (r_more && 32'(r_count) < JOB_SLOTS) begin
                    q_we    = 1'b1;
                    q_wa    = tail_idx;
                    n_count = r_count + 1'b1;
                end
            end

            S_FWAIT: begin
                n_valid    = 1'b1;
                n_state    = S_IDLE;
                n_slot_out = r_slot;
                au_a       = r_tbl_q.next;
                au_b       = r_tbl_q.total;
                au_sub     = 1'b1;
                if (r_tbl_q.inflight == '0) begin
                    n_status = ST_IGNORED;
                end else begin
                    tbl_we          = 1'b1;
                    tbl_wa          = r_slot;
                    tbl_wd          = r_tbl_q;
                    tbl_wd.inflight = r_tbl_q.inflight - 1'b1;
                    if (!au_ge || tbl_wd.inflight != '0 || r_done_flags[r_slot]) begin
                        n_status = ST_FINISHED;
                    end else begin
                        n_done_flags[r_slot] = 1'b1;
                        n_busy_flags[r_slot] = 1'b0;
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                        n_status = ST_COMPLETE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy_flags <= '0;
            r_done_flags <= '0;
            r_first      <= '0;
            r_count      <= '0;
            r_live       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy_flags <= n_busy_flags;
            r_done_flags <= n_done_flags;
            r_first      <= n_first;
            r_count      <= n_count;
            r_live       <= n_live;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_slot      <= n_slot;
        r_total     <= n_total;
        r_grain     <= n_grain;
        r_ent       <= n_ent;
        r_rem       <= n_rem;
        r_end       <= n_end;
        r_more      <= n_more;
        r_status    <= n_status;
        r_slot_out  <= n_slot_out;
        r_begin_out <= n_begin_out;
        r_end_out   <= n_end_out;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_range_lo    = r_begin_out;
    assign o_range_hi    = r_end_out;
    assign o_jobs_active = r_live;

endmodule
